FILE: src/sdp_pkg.sv
`timescale 1ns / 1ps
package sdp_pkg;

  // pixel coordinate width actually used
  localparam int COORD_BITS = 12;
  localparam int FOCAL_W    = 20;
  localparam int BASE_W     = 24;
  localparam int MAXD_W     = 7;
  localparam int DISP_W     = 12;
  localparam int GRAY_W     = 8;
  localparam int OUT_W      = 32;
  localparam int APB_DW     = 32;
  localparam int ADDR_W     = 5;

  // derived arithmetic widths
  localparam int PIX_W  = COORD_BITS + 8;
  localparam int DIFF_W = (PIX_W > FOCAL_W) ? PIX_W : FOCAL_W;
  localparam int PROD_W = DIFF_W + BASE_W;
  localparam int NUM_W  = PROD_W + FOCAL_W;
  localparam int DMAG_W = DISP_W - 1;
  localparam int DEN_W  = DMAG_W + 4 + FOCAL_W;
  localparam int LO_W   = PROD_W / 2;
  localparam int HI_W   = PROD_W - LO_W;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_BASELINE = 3'd4,
    REG_MAX_DISP = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [11:0]              column;
    logic [11:0]              row;
    logic signed [DISP_W-1:0] disparity_raw;
    logic [GRAY_W-1:0]        intensity;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic [OUT_W-1:0]        point_z;
    logic [GRAY_W-1:0]       point_gray;
  } point_t;

  typedef struct packed {
    logic [FOCAL_W-1:0] focal_x;
    logic [FOCAL_W-1:0] focal_y;
    logic [FOCAL_W-1:0] center_x;
    logic [FOCAL_W-1:0] center_y;
    logic [BASE_W-1:0]  baseline;
    logic [MAXD_W-1:0]  max_disparity;
  } cfg_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [DIFF_W-1:0] du;
    logic              neg_x;
    logic [DIFF_W-1:0] dv;
    logic              neg_y;
    logic [DMAG_W-1:0] disp;
    logic [GRAY_W-1:0] gray;
  } item_t;

endpackage

FILE: src/sdp_front.sv
`timescale 1ns / 1ps
module sdp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdp_pkg::pixel_t pixel,
  input  sdp_pkg::cfg_t  cfg,
  input  logic           q_full,
  output logic           push,
  output sdp_pkg::item_t push_item
);
  import sdp_pkg::*;

  logic              held;
  item_t             item;
  logic              accept;
  logic              keep;
  logic [PIX_W-1:0]  u_pix;
  logic [PIX_W-1:0]  v_pix;
  logic [DIFF_W-1:0] u_ext;
  logic [DIFF_W-1:0] v_ext;
  logic [DIFF_W-1:0] cx_ext;
  logic [DIFF_W-1:0] cy_ext;
  item_t             item_next;

  // stall only while a held pixel cannot enter the queue
  assign busy   = held && q_full;
  assign accept = start && !busy;
  assign push   = held && !q_full;
  assign push_item = item;

  // disparity must be positive and below the limit
  always_comb begin
    keep = !pixel.disparity_raw[DISP_W-1] && (pixel.disparity_raw != '0) &&
           (pixel.disparity_raw[DMAG_W-1:0] < {cfg.max_disparity, 4'b0000});
    u_pix  = {pixel.column[COORD_BITS-1:0], 8'h00};
    v_pix  = {pixel.row[COORD_BITS-1:0], 8'h00};
    u_ext  = DIFF_W'(u_pix);
    v_ext  = DIFF_W'(v_pix);
    cx_ext = DIFF_W'(cfg.center_x);
    cy_ext = DIFF_W'(cfg.center_y);
    item_next.neg_x = u_ext < cx_ext;
    item_next.du    = item_next.neg_x ? (cx_ext - u_ext) : (u_ext - cx_ext);
    item_next.neg_y = v_ext < cy_ext;
    item_next.dv    = item_next.neg_y ? (cy_ext - v_ext) : (v_ext - cy_ext);
    item_next.disp  = pixel.disparity_raw[DMAG_W-1:0];
    item_next.gray  = pixel.intensity;
  end

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= keep;
    end else if (!q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

FILE: src/sdp_queue.sv
`timescale 1ns / 1ps
module sdp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sdp_pkg::item_t push_item,
  output logic           full,
  output logic           head_valid,
  output sdp_pkg::item_t head
);
  import sdp_pkg::*;

  item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               pop;

  // back end drains every cycle
  assign head_valid = count != '0;
  assign pop        = head_valid;
  assign full       = count == Q_CNT_W'(Q_DEPTH);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: src/sdp_div.sv
`timescale 1ns / 1ps
module sdp_div (
  input  logic                       clk,
  input  logic [sdp_pkg::NUM_W-1:0]  num,
  input  logic [sdp_pkg::DEN_W-1:0]  den,
  output logic [sdp_pkg::NUM_W-1:0]  quo
);
  import sdp_pkg::*;

  // one quotient bit per stage, restoring
  logic [DEN_W-1:0] rem [NUM_W-1];
  logic [NUM_W-1:0] nq  [NUM_W];
  logic [DEN_W-1:0] dd  [NUM_W-1];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W-1:0] r_in;
    logic [NUM_W-1:0] n_in;
    logic [DEN_W-1:0] d_in;
    logic [DEN_W:0]   trial;
    logic             take;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign n_in = nq[s-1];
      assign d_in = dd[s-1];
    end

    assign trial = {r_in, n_in[NUM_W-1]};
    assign take  = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      nq[s] <= {n_in[NUM_W-2:0], take};
    end

    if (s < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[s] <= take ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
        dd[s]  <= d_in;
      end
    end
  end

  assign quo = nq[NUM_W-1];

endmodule

FILE: src/sdp_back.sv
`timescale 1ns / 1ps
module sdp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  sdp_pkg::item_t in_item,
  input  sdp_pkg::cfg_t  cfg,
  output logic           result_valid,
  output sdp_pkg::point_t result
);
  import sdp_pkg::*;

  typedef struct packed {
    logic              valid;
    logic              neg_x;
    logic              neg_y;
    logic              zero_fx;
    logic              zero_fy;
    logic [GRAY_W-1:0] gray;
  } side_t;

  localparam int LAT = NUM_W + 3;

  // sign-magnitude to saturated signed 32 bits
  function automatic logic [OUT_W-1:0] sat_s32(input logic [NUM_W-1:0] mag, input logic neg);
    logic big;
    big = |mag[NUM_W-1:OUT_W-1];
    if (neg) begin
      sat_s32 = (big) ? {1'b1, {(OUT_W-1){1'b0}}} : (OUT_W'(0) - mag[OUT_W-1:0]);
    end else begin
      sat_s32 = (big) ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
    end
  endfunction

  side_t                    side [LAT];
  side_t                    side_in;
  logic [PROD_W-1:0]        num_z1, num_x1, dvb1;
  logic [DEN_W-1:0]         den_z1, den_y1;
  logic [FOCAL_W-1:0]       fx1;
  logic [LO_W+FOCAL_W-1:0]  p_lo2;
  logic [HI_W+FOCAL_W-1:0]  p_hi2;
  logic [PROD_W-1:0]        num_z2, num_x2, num_z3, num_x3;
  logic [DEN_W-1:0]         den_z2, den_y2, den_z3, den_y3;
  logic [NUM_W-1:0]         num_y3;
  logic [NUM_W-1:0]         q_z, q_x, q_y;
  side_t                    side_out;

  always_comb begin
    side_in.valid   = in_valid;
    side_in.neg_x   = in_item.neg_x;
    side_in.neg_y   = in_item.neg_y;
    side_in.zero_fx = cfg.focal_x == '0;
    side_in.zero_fy = cfg.focal_y == '0;
    side_in.gray    = in_item.gray;
  end

  // sideband delay line matching the arithmetic, valid bits cleared by reset
  always_ff @(posedge clk) begin
    side[0].valid   <= rst ? 1'b0 : side_in.valid;
    side[0].neg_x   <= side_in.neg_x;
    side[0].neg_y   <= side_in.neg_y;
    side[0].zero_fx <= side_in.zero_fx;
    side[0].zero_fy <= side_in.zero_fy;
    side[0].gray    <= side_in.gray;
    for (int i = 1; i < LAT; i++) begin
      side[i].valid   <= rst ? 1'b0 : side[i-1].valid;
      side[i].neg_x   <= side[i-1].neg_x;
      side[i].neg_y   <= side[i-1].neg_y;
      side[i].zero_fx <= side[i-1].zero_fx;
      side[i].zero_fy <= side[i-1].zero_fy;
      side[i].gray    <= side[i-1].gray;
    end
  end

  // stage 1: numerators and denominators
  always_ff @(posedge clk) begin
    num_z1 <= PROD_W'(cfg.focal_x) * PROD_W'(cfg.baseline);
    num_x1 <= PROD_W'(in_item.du) * PROD_W'(cfg.baseline);
    dvb1   <= PROD_W'(in_item.dv) * PROD_W'(cfg.baseline);
    den_z1 <= DEN_W'({in_item.disp, 4'b0000});
    den_y1 <= DEN_W'({in_item.disp, 4'b0000}) * DEN_W'(cfg.focal_y);
    fx1    <= cfg.focal_x;
  end

  // stage 2: y numerator as two partial products
  always_ff @(posedge clk) begin
    p_lo2  <= (LO_W+FOCAL_W)'(dvb1[LO_W-1:0]) * (LO_W+FOCAL_W)'(fx1);
    p_hi2  <= (HI_W+FOCAL_W)'(dvb1[PROD_W-1:LO_W]) * (HI_W+FOCAL_W)'(fx1);
    num_z2 <= num_z1;
    num_x2 <= num_x1;
    den_z2 <= den_z1;
    den_y2 <= den_y1;
  end

  // stage 3: combine partial products
  always_ff @(posedge clk) begin
    num_y3 <= (NUM_W'(p_hi2) << LO_W) + NUM_W'(p_lo2);
    num_z3 <= num_z2;
    num_x3 <= num_x2;
    den_z3 <= den_z2;
    den_y3 <= den_y2;
  end

  sdp_div u_div_z (.clk(clk), .num(NUM_W'(num_z3)), .den(den_z3), .quo(q_z));
  sdp_div u_div_x (.clk(clk), .num(NUM_W'(num_x3)), .den(den_z3), .quo(q_x));
  sdp_div u_div_y (.clk(clk), .num(num_y3), .den(den_y3), .quo(q_y));

  assign side_out = side[LAT-1];

  // saturation and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= side_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    result.point_gray <= side_out.gray;
    if (side_out.zero_fx) begin
      result.point_z <= '0;
      result.point_x <= '0;
      result.point_y <= '0;
    end else begin
      result.point_z <= (|q_z[NUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : q_z[OUT_W-1:0];
      result.point_x <= sat_s32(q_x, side_out.neg_x);
      result.point_y <= side_out.zero_fy ? '0 : sat_s32(q_y, side_out.neg_y);
    end
  end

endmodule

FILE: src/stereo_disparity_to_point_unit.sv
`timescale 1ns / 1ps
// Stereo disparity to 3-D point reprojection (pinhole camera).
// Input: one pixel per transfer on pixel, taken at a clock edge with start
// high and busy low. Pixels with disparity not in (0, 16*max_disparity) are
// dropped in the front end and give no result.
// Output: result_valid marks a point on result for exactly one cycle; the
// receiver cannot stall, the back end runs without any hold.
// Throughput: one pixel per clock, sustained. busy rises only if the
// four-entry queue between front and back fills, which the free-running
// back end never lets happen in normal use.
// Arithmetic: pipelined restoring dividers, one quotient bit per stage.
// Configuration: APB registers at byte address 4*index, written by the
// user only while no pixel is in flight; the block does not enforce this.
// Reset restores register defaults and empties the pipeline; no result
// appears for pixels taken before reset.
module stereo_disparity_to_point_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sdp_pkg::pixel_t           pixel,
  output logic                      result_valid,
  output sdp_pkg::point_t           result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sdp_pkg::ADDR_W-1:0] paddr,
  input  logic [sdp_pkg::APB_DW-1:0] pwdata,
  output logic [sdp_pkg::APB_DW-1:0] prdata,
  output logic                      pready
);
  import sdp_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     q_full;
  logic     push;
  item_t    push_item;
  logic     head_valid;
  item_t    head;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x       <= FOCAL_W'(256);
      cfg.focal_y       <= FOCAL_W'(256);
      cfg.center_x      <= '0;
      cfg.center_y      <= '0;
      cfg.baseline      <= BASE_W'(65536);
      cfg.max_disparity <= MAXD_W'(96);
    end else if (wr_en) begin
      case (reg_idx)
        REG_FOCAL_X:  cfg.focal_x       <= pwdata[FOCAL_W-1:0];
        REG_FOCAL_Y:  cfg.focal_y       <= pwdata[FOCAL_W-1:0];
        REG_CENTER_X: cfg.center_x      <= pwdata[FOCAL_W-1:0];
        REG_CENTER_Y: cfg.center_y      <= pwdata[FOCAL_W-1:0];
        REG_BASELINE: cfg.baseline      <= pwdata[BASE_W-1:0];
        REG_MAX_DISP: cfg.max_disparity <= pwdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_FOCAL_X:  prdata = APB_DW'(cfg.focal_x);
      REG_FOCAL_Y:  prdata = APB_DW'(cfg.focal_y);
      REG_CENTER_X: prdata = APB_DW'(cfg.center_x);
      REG_CENTER_Y: prdata = APB_DW'(cfg.center_y);
      REG_BASELINE: prdata = APB_DW'(cfg.baseline);
      REG_MAX_DISP: prdata = APB_DW'(cfg.max_disparity);
      default:      prdata = '0;
    endcase
  end

  sdp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel     (pixel),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  sdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  sdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (head_valid),
    .in_item      (head),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: src/sdp_checker.sv
`timescale 1ns / 1ps
module sdp_checker (
  input logic            clk,
  input logic            rst,
  input logic            busy,
  input logic            result_valid,
  input logic            pready,
  input sdp_pkg::point_t result
);

  // nothing comes out straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  // front end is free after reset
  a_reset_free: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy right after reset");

  // apb never waits
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  // a strobed point carries no unknown bits
  a_known_point: assert property (@(posedge clk) disable iff (rst)
      result_valid |-> !$isunknown(result))
    else $error("unknown bits on strobed point");

endmodule

bind stereo_disparity_to_point_unit sdp_checker u_sdp_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .pready       (pready),
  .result       (result)
);

FILE: test/point_checker.sv
`timescale 1ns / 1ps
module point_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  sdp_pkg::pixel_t pixel,
  input  logic            result_valid,
  input  sdp_pkg::point_t result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [sdp_pkg::ADDR_W-1:0] paddr,
  input  logic [sdp_pkg::APB_DW-1:0] pwdata,
  output int              errors,
  output int              points_pending
);
  import sdp_pkg::*;

  cfg_t   cam;
  point_t expected_points[$];

  // floor(a*b/den), saturated to 64 bits
  function automatic logic [63:0] scaled_quotient(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, den};
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  function automatic logic [31:0] signed_sat(logic [63:0] mag, logic neg);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  // reprojection of one pixel; returns 0 when the disparity is rejected
  function automatic bit reproject(pixel_t p, output point_t pt);
    logic [63:0] u, v, d, du, dv, mag, fx, fy, cx, cy, bl;
    logic neg;
    pt = '0;
    pt.point_gray = p.intensity;
    fx = 64'(cam.focal_x);
    fy = 64'(cam.focal_y);
    cx = 64'(cam.center_x);
    cy = 64'(cam.center_y);
    bl = 64'(cam.baseline);
    d = {52'd0, p.disparity_raw};
    if (p.disparity_raw[DISP_W-1] || d == 0 || d >= 64'(cam.max_disparity) * 16)
      return 0;
    d = d * 16;
    u = 64'(p.column[COORD_BITS-1:0]) << 8;
    v = 64'(p.row[COORD_BITS-1:0]) << 8;
    if (fx != 0) begin
      mag = scaled_quotient(fx, bl, d);
      pt.point_z = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
      neg = u < cx;
      du = neg ? cx - u : u - cx;
      pt.point_x = signed_sat(scaled_quotient(du, bl, d), neg);
      if (fy != 0) begin
        neg = v < cy;
        dv = neg ? cy - v : v - cy;
        mag = scaled_quotient(dv * bl, fx, d * fy);
        pt.point_y = signed_sat(mag, neg);
      end
    end
    return 1;
  endfunction

  assign points_pending = expected_points.size();

  always @(posedge clk) begin
    point_t pt, want;
    int bad;
    bad = 0;
    if (rst) begin
      cam <= '{256, 256, 0, 0, 65536, 96};
      errors <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready)
        case (reg_idx_t'(paddr[4:2]))
          REG_FOCAL_X:  cam.focal_x <= pwdata[FOCAL_W-1:0];
          REG_FOCAL_Y:  cam.focal_y <= pwdata[FOCAL_W-1:0];
          REG_CENTER_X: cam.center_x <= pwdata[FOCAL_W-1:0];
          REG_CENTER_Y: cam.center_y <= pwdata[FOCAL_W-1:0];
          REG_BASELINE: cam.baseline <= pwdata[BASE_W-1:0];
          REG_MAX_DISP: cam.max_disparity <= pwdata[MAXD_W-1:0];
          default: ;
        endcase
      // pixel transfer
      if (start && !busy && reproject(pixel, pt)) expected_points = {expected_points, pt};
      // result transfer
      if (result_valid) begin
        if (expected_points.size() == 0) begin
          $error("unexpected point %h", result);
          bad++;
        end else begin
          want = expected_points.pop_front();
          if (result.point_x !== want.point_x) begin
            $error("point_x expected %h actual %h", want.point_x, result.point_x);
            bad++;
          end
          if (result.point_y !== want.point_y) begin
            $error("point_y expected %h actual %h", want.point_y, result.point_y);
            bad++;
          end
          if (result.point_z !== want.point_z) begin
            $error("point_z expected %h actual %h", want.point_z, result.point_z);
            bad++;
          end
          if (result.point_gray !== want.point_gray) begin
            $error("point_gray expected %h actual %h", want.point_gray,
                   result.point_gray);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sdp_pkg::*;

  localparam int LATENCY = 80;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst, start, busy, result_valid;
  pixel_t pixel;
  point_t result;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  int errors, points_pending, cycles;

  stereo_disparity_to_point_unit dut (.*);

  point_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= (rst ? 0 : cycles + 1);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // setup, access, then idle
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // wait out everything in flight
  task automatic drain();
    int n;
    n = 0;
    start <= 0;
    while (points_pending != 0) @(posedge clk);
    while (n < LATENCY) begin
      @(posedge clk);
      n++;
    end
  endtask

  // start stays high into the next pixel when there is no gap
  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [11:0] d,
                            logic [7:0] g, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) wait_n = 0;
    if (wait_n > 0) begin
      start <= 0;
      repeat (wait_n) @(posedge clk);
    end
    start <= 1;
    pixel <= '{c, r, d, g};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // mostly valid disparities, some out of range
  function automatic logic [11:0] pick_disp();
    case ($urandom_range(0, 9))
      0: return 12'($urandom);
      1: return 12'h800 | 12'($urandom);
      2: return 12'd1;
      default: return 12'($urandom_range(1, 2047));
    endcase
  endfunction

  task automatic camera_setup(logic [19:0] fx, logic [19:0] fy, logic [19:0] cx,
                              logic [19:0] cy, logic [23:0] b, logic [6:0] md);
    drain();
    reg_write(REG_FOCAL_X, fx);
    reg_write(REG_FOCAL_Y, fy);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_BASELINE, b);
    reg_write(REG_MAX_DISP, md);
  endtask

  task automatic random_phase(int n);
    repeat (n)
      send_pixel(12'($urandom), 12'($urandom), pick_disp(), 8'($urandom), 1);
  endtask

  initial begin
    rst = 1; start = 0; pixel = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes and rejected disparities at reset settings
    send_pixel(0, 0, 12'd1, 0, 0);
    send_pixel(12'hFFF, 12'hFFF, 12'd1535, 8'hFF, 0);
    send_pixel(5, 6, 12'd1536, 8'h11, 0);
    send_pixel(5, 6, 12'd0, 8'h22, 0);
    send_pixel(5, 6, 12'h800, 8'h33, 0);
    send_pixel(5, 6, 12'hFFF, 8'h44, 0);
    send_pixel(12'hAAA, 12'h555, 12'd16, 8'h5A, 0);
    // overflow: large focal and baseline, small disparity
    camera_setup('1, '1, 0, '1, '1, 7'd127);
    send_pixel(12'hFFF, 0, 12'd1, 8'hA5, 0);
    send_pixel(0, 12'hFFF, 12'd2031, 8'h5A, 0);
    send_pixel(12'hFFF, 12'hFFF, 12'd2032, 8'h01, 0);
    // zero focal lengths
    camera_setup(0, 20'd300, 20'h8000, 20'h8000, 24'h20000, 7'd1);
    send_pixel(10, 10, 12'd15, 8'h10, 0);
    send_pixel(10, 10, 12'd16, 8'h10, 0);
    camera_setup(20'h1F400, 0, 20'h50000, 20'h3C000, 24'h1E00, 7'd64);
    send_pixel(12'h100, 12'h100, 12'd100, 8'h20, 0);
    send_pixel(0, 0, 12'd1023, 8'h20, 0);
    // zero disparity limit rejects every pixel
    camera_setup(20'h1F400, 20'h1F400, 20'h50000, 20'h3C000, 24'h1E00, 7'd0);
    send_pixel(1, 1, 12'd5, 8'h30, 0);
    // random phases over several settings
    camera_setup(20'h1F400, 20'h1F300, 20'h50000, 20'h3C000, 24'h1E00, 7'd127);
    random_phase(100);
    camera_setup(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                 24'($urandom), 7'($urandom_range(1, 127)));
    random_phase(100);
    camera_setup(20'd1, 20'd1, '1, '1, 24'd1, 7'd127);
    random_phase(50);
    camera_setup(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                 24'($urandom), 7'($urandom_range(1, 127)));
    random_phase(50);
    drain();
    // back-to-back stretch
    repeat (100)
      send_pixel(12'($urandom), 12'($urandom), pick_disp(), 8'($urandom), 0);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: files.f
src/sdp_pkg.sv
src/sdp_front.sv
src/sdp_queue.sv
src/sdp_div.sv
src/sdp_back.sv
src/stereo_disparity_to_point_unit.sv
src/sdp_checker.sv
test/point_checker.sv
test/testbench.sv
